@@ design/tcw_pkg.sv @@
// shared types, constants and command/status structs for the text console writer
// no dependencies; imported by every module of the block

package tcw_pkg;

    localparam int DEF_ROWS    = 25;
    localparam int DEF_COLS    = 80;

    localparam int CHAR_W      = 8;
    localparam int ATTR_W      = 8;
    localparam int ADDR_PORT_W = 11;
    localparam int ROW_PORT_W  = 5;
    localparam int COL_PORT_W  = 7;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
    localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'd0;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_FILL
    } tcw_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic fill_step;
        logic load_read;
    } tcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_read;
        logic put_scrolls;
        logic sweep_last;
    } tcw_status_t;

endpackage

@@ design/tcw_ctrl.sv @@
// controller state machine: clear pass, item acceptance, read wait and bottom-row fill
// depends on tcw_pkg

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        out_ready,
    input  tcw_status_t status,
    output logic        in_ready,
    output logic        out_valid,
    output tcw_cmd_t    cmd
);

    tcw_state_t state_reg;
    tcw_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                // one item at a time: output slot must be free or emptying now
                in_ready   = !out_valid_reg || out_ready;
                cmd.accept = in_valid && in_ready;
                if (cmd.accept)
                begin
                    priority if (status.item_read)
                    begin
                        state_next = ST_READ;
                    end
                    else if (status.put_scrolls)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                cmd.load_read = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase

        out_valid_next = (out_valid_reg && !out_ready)
                       || (cmd.accept && !status.item_read)
                       || cmd.load_read;
    end

    assign out_valid = out_valid_reg;

endmodule

@@ design/tcw_dp.sv @@
// datapath: screen store, cursor, scroll offset, sweep counter and result registers
// depends on tcw_pkg; driven by tcw_ctrl through tcw_cmd_t

module tcw_dp
    import tcw_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcw_cmd_t               cmd,
    output tcw_status_t            status,
    input  logic                   func,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [ADDR_PORT_W-1:0] cell_address,
    input  logic                   cfg_we,
    input  logic [ATTR_W-1:0]      text_attribute,
    output logic [CHAR_W-1:0]      read_char,
    output logic [ATTR_W-1:0]      read_attr,
    output logic [ROW_PORT_W-1:0]  cursor_row,
    output logic [COL_PORT_W-1:0]  cursor_col,
    output logic                   scrolled
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS);
    localparam int SUM_W  = ADDR_W + 1;
    localparam int RD_W   = ((ADDR_W > ADDR_PORT_W) ? ADDR_W : ADDR_PORT_W) + 1;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [SUM_W-1:0]  CELLS_S   = SUM_W'(CELLS);
    localparam logic [SUM_W-1:0]  COLS_S    = SUM_W'(COLS);
    localparam logic [RD_W-1:0]   CELLS_R   = RD_W'(CELLS);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COLS_C    = (COL_W + 1)'(COLS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_FILL = ADDR_W'(COLS - 1);

    logic [CELL_W-1:0] mem [CELLS];

    // control state
    logic [ROW_W-1:0]  row_reg,       row_next;
    logic [COL_W-1:0]  col_reg,       col_next;
    logic [ADDR_W-1:0] phys_line_reg, phys_line_next;
    logic [ADDR_W-1:0] base_reg,      base_next;
    logic [ADDR_W-1:0] sweep_reg,     sweep_next;
    logic [ATTR_W-1:0] attr_reg;

    // payload
    logic [CELL_W-1:0]     rd_data_reg;
    logic                  rd_in_range_reg;
    logic [CHAR_W-1:0]     read_char_reg;
    logic [ATTR_W-1:0]     read_attr_reg;
    logic [ROW_PORT_W-1:0] row_out_reg;
    logic [COL_PORT_W-1:0] col_out_reg;
    logic                  scrolled_reg;

    logic              is_read;
    logic              is_nl;
    logic              is_print;
    logic [COL_W:0]    col_inc;
    logic              wraps;
    logic              nl_go;
    logic              scroll;
    logic [SUM_W-1:0]  line_step;
    logic [SUM_W-1:0]  base_step;
    logic [COL_W-1:0]  offset;
    logic [SUM_W-1:0]  cell_sum;
    logic [ADDR_W-1:0] cell_addr;
    logic [RD_W-1:0]   rd_sum;
    logic [RD_W-1:0]   rd_phys;
    logic              in_range;
    logic              rd_en;
    logic              sweep_last;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    always_comb
    begin
        is_read  = (func == FUNC_READ);
        is_nl    = (char_code == NEWLINE_CHAR);
        is_print = (char_code != NUL_CHAR) && !is_nl;
        col_inc  = {1'b0, col_reg} + 1'b1;
        wraps    = is_print && (col_inc == COLS_C);
        nl_go    = !is_read && (is_nl || wraps);
        scroll   = nl_go && (row_reg == LAST_ROW);

        // physical line start and screen top move one row, modulo store size
        line_step = {1'b0, phys_line_reg} + COLS_S;
        if (line_step >= CELLS_S)
        begin
            line_step = line_step - CELLS_S;
        end
        base_step = {1'b0, base_reg} + COLS_S;
        if (base_step >= CELLS_S)
        begin
            base_step = base_step - CELLS_S;
        end

        // cell on the cursor line: cursor column for a put, sweep column for a fill
        offset   = cmd.fill_step ? sweep_reg[COL_W-1:0] : col_reg;
        cell_sum = {1'b0, phys_line_reg} + SUM_W'(offset);
        if (cell_sum >= CELLS_S)
        begin
            cell_sum = cell_sum - CELLS_S;
        end
        cell_addr = cell_sum[ADDR_W-1:0];

        // read address relative to the current screen top
        in_range = (RD_W'(cell_address) < CELLS_R);
        rd_sum   = RD_W'(cell_address) + RD_W'(base_reg);
        rd_phys  = (rd_sum >= CELLS_R) ? (rd_sum - CELLS_R) : rd_sum;
        rd_en    = cmd.accept && is_read && in_range;

        sweep_last = cmd.clear_step ? (sweep_reg == LAST_CELL) : (sweep_reg == LAST_FILL);
        sweep_next = sweep_reg;
        if (cmd.clear_step || cmd.fill_step)
        begin
            sweep_next = sweep_last ? '0 : (sweep_reg + 1'b1);
        end

        row_next       = row_reg;
        col_next       = col_reg;
        phys_line_next = phys_line_reg;
        base_next      = base_reg;
        if (cmd.accept && !is_read)
        begin
            if (nl_go)
            begin
                col_next       = '0;
                phys_line_next = line_step[ADDR_W-1:0];
                if (scroll)
                begin
                    base_next = base_step[ADDR_W-1:0];
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else if (is_print)
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end

        priority if (cmd.clear_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = {ATTR_W'(0), SPACE_CHAR};
        end
        else if (cmd.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr;
            mem_wdata = {attr_reg, SPACE_CHAR};
        end
        else
        begin
            mem_we    = cmd.accept && !is_read && is_print;
            mem_waddr = cell_addr;
            mem_wdata = {attr_reg, char_code};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            phys_line_reg <= '0;
            base_reg      <= '0;
            sweep_reg     <= '0;
            attr_reg      <= ATTR_RESET;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            phys_line_reg <= phys_line_next;
            base_reg      <= base_next;
            sweep_reg     <= sweep_next;
            if (cfg_we)
            begin
                attr_reg <= text_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_phys[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_in_range_reg <= in_range;
            read_char_reg   <= '0;
            read_attr_reg   <= '0;
            row_out_reg     <= ROW_PORT_W'(row_next);
            col_out_reg     <= COL_PORT_W'(col_next);
            scrolled_reg    <= scroll;
        end
        else if (cmd.load_read)
        begin
            read_char_reg <= rd_in_range_reg ? rd_data_reg[CHAR_W-1:0] : '0;
            read_attr_reg <= rd_in_range_reg ? rd_data_reg[CELL_W-1:CHAR_W] : '0;
        end
    end

    assign status.item_read   = is_read;
    assign status.put_scrolls = scroll;
    assign status.sweep_last  = sweep_last;

    assign read_char  = read_char_reg;
    assign read_attr  = read_attr_reg;
    assign cursor_row = row_out_reg;
    assign cursor_col = col_out_reg;
    assign scrolled   = scrolled_reg;

endmodule

@@ design/text_console_writer_unit.sv @@
// top level of the text console writer: controller plus datapath
// depends on tcw_pkg, tcw_ctrl and tcw_dp
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   in       | in_valid / in_ready   | func, char_code, cell_address
//   out      | out_valid / out_ready | read_char, read_attr, cursor_row,
//            |                       | cursor_col, scrolled
//   cfg      | cfg_valid / cfg_ready | text_attribute
//
// results: a put or NUL transaction has its result registered in the cycle after acceptance and
//   the next item may follow at once; a read passes first through the registered read port of
//   the screen store and then, in the read-wait state, into the result register
// a scroll is followed by a fill pass in which the bottom row is filled with
//   spaces through the single write port; rows are never copied
// reset: a clearing pass writes every one of the ROWS*COLS cells (2000 by default),
//   with input held off; configuration transactions are taken throughout
// stalls: one item is in flight at a time; a new one is taken once the output
//   register is empty or being emptied in the same cycle

module text_console_writer_unit
    import tcw_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   func,
    input  logic [CHAR_W-1:0]      char_code,
    input  logic [ADDR_PORT_W-1:0] cell_address,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CHAR_W-1:0]      read_char,
    output logic [ATTR_W-1:0]      read_attr,
    output logic [ROW_PORT_W-1:0]  cursor_row,
    output logic [COL_PORT_W-1:0]  cursor_col,
    output logic                   scrolled,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ATTR_W-1:0]      text_attribute
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    // attribute register can always take a transaction
    assign cfg_ready = 1'b1;

    // sequencing: clear pass, accept, read wait, bottom-row fill
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // scrolling moves a screen-top offset in the store; the cursor line start is
    // kept as a physical address so no multiply or divide sits in any path
    tcw_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .func           (func),
        .char_code      (char_code),
        .cell_address   (cell_address),
        .cfg_we         (cfg_valid && cfg_ready),
        .text_attribute (text_attribute),
        .read_char      (read_char),
        .read_attr      (read_attr),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col),
        .scrolled       (scrolled)
    );

endmodule

@@ design/tcw_checker.sv @@
// port-level checks for the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer_unit

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int ROWS = DEF_ROWS,
    parameter int COLS = DEF_COLS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   func,
    input logic [ADDR_PORT_W-1:0] cell_address,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [CHAR_W-1:0]      read_char,
    input logic [ATTR_W-1:0]      read_attr,
    input logic [ROW_PORT_W-1:0]  cursor_row,
    input logic [COL_PORT_W-1:0]  cursor_col,
    input logic                   scrolled
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_char) && $stable(read_attr)
            && $stable(cursor_row) && $stable(cursor_col) && $stable(scrolled))
        else $error("result changed while stalled");

    // a scroll always leaves the cursor at the start of the last row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |->
            cursor_col == '0 && cursor_row == ROW_PORT_W'(ROWS - 1))
        else $error("scroll with cursor off the last row start");

    // cursor column never rests past the row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(cursor_col) < COLS)
        else $error("cursor column out of range");

    // a put transaction returns its result next cycle with empty read fields
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_PUT |=>
            out_valid && read_char == '0 && read_attr == '0)
        else $error("put result missing or carries read data");

    // a read beyond the store returns zero cell data
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FUNC_READ && 32'(cell_address) >= ROWS * COLS |->
            ##2 out_valid && read_char == '0 && read_attr == '0 && !scrolled)
        else $error("out-of-range read returned data");

endmodule

bind text_console_writer_unit tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (.*);
